[rtl/otpf_pkg.sv]
// Shared types, constants and register indexes for the off-track pixel fraction detector.
package otpf_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W = 8;
    localparam int CFG_W = 13;
    localparam int CNT_W = 24;
    localparam int IDX_W = 2;
    localparam int DAT_W = 24;

    localparam int MIN_WIDTH  = 4;
    localparam int MIN_HEIGHT = 1;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [CFG_W-1:0] t_size;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0] t_reg_idx;
    typedef logic [DAT_W-1:0] t_reg_data;

    localparam t_count CNT_MAX = {CNT_W{1'b1}};

    localparam t_reg_idx REG_FRAME_WIDTH     = 2'd0;
    localparam t_reg_idx REG_FRAME_HEIGHT    = 2'd1;
    localparam t_reg_idx REG_GREY_TOLERANCE  = 2'd2;
    localparam t_reg_idx REG_OFF_TRACK_LIMIT = 2'd3;

    localparam t_size  RST_FRAME_WIDTH     = 13'd1920;
    localparam t_size  RST_FRAME_HEIGHT    = 13'd580;
    localparam t_pixel RST_GREY_TOLERANCE  = 8'd5;
    localparam t_count RST_OFF_TRACK_LIMIT = 24'd167040;

endpackage

[rtl/otpf_if.sv]
// Stream and register-write interfaces of the off-track pixel fraction detector.
interface otpf_pix_if;
    import otpf_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel blue_value;
    t_pixel green_value;
    t_pixel red_value;
    modport source (output valid, blue_value, green_value, red_value, input ready);
    modport sink   (input valid, blue_value, green_value, red_value, output ready);
endinterface

interface otpf_res_if;
    import otpf_pkg::*;
    logic   valid;
    logic   ready;
    t_count nongrey_total;
    t_count left_total;
    t_count right_total;
    logic   off_track;
    logic   leaving_left;
    logic   leaving_right;
    modport source (output valid, nongrey_total, left_total, right_total, off_track,
                    leaving_left, leaving_right, input ready);
    modport sink   (input valid, nongrey_total, left_total, right_total, off_track,
                    leaving_left, leaving_right, output ready);
endinterface

interface otpf_cfg_if;
    import otpf_pkg::*;
    logic      valid;
    logic      ready;
    t_reg_idx  index;
    t_reg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/off_track_pixel_fraction_detector_top.sv]
// Off-track pixel fraction detector: pixel classification, band counting and frame result.
// Pipeline: a pixel is classified into the input register on acceptance; from there it
// updates the counters and, at the last pixel of a frame, loads the result register.
// Throughput: one pixel per cycle; the input stalls only while a frame result waits.
// Reset (i_rst_n low, synchronous): registers go to their defaults, positions, counters
// and side flags clear, both stages empty.
module off_track_pixel_fraction_detector_top #(
    parameter int MAX_WIDTH  = otpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = otpf_pkg::DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    otpf_pix_if.sink   i_pix,
    otpf_cfg_if.sink   i_cfg,
    otpf_res_if.source o_res
);
    import otpf_pkg::*;

    // Effective size widths hold the maximum itself; positions hold max-1.
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHW = (HW > CFG_W) ? HW : CFG_W;

    // Configuration registers
    t_size  r_frame_width;
    t_size  r_frame_height;
    t_pixel r_grey_tolerance;
    t_count r_off_track_limit;

    // Pipeline state
    logic          r_s1_valid;
    logic          r_s1_nongrey;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_count        r_band;
    t_count        r_left;
    t_count        r_right;
    logic          r_side_left;
    logic          r_side_right;

    // Result register
    logic   r_out_valid;
    t_count r_out_band;
    t_count r_out_left;
    t_count r_out_right;
    logic   r_out_off;
    logic   r_out_lleft;
    logic   r_out_lright;

    // Combinational
    logic [PIX_W:0]  diff_bg, diff_br;
    logic            nongrey;
    logic [CWW-1:0]  w_ext;
    logic [CHW-1:0]  h_ext;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [WW-1:0]   col_ext;
    logic [WW+1:0]   col_x4, w_x3;
    logic            in_band, on_left, hit;
    logic            row_end, frame_end;
    logic            out_free, s1_go, in_ready;
    t_count          n_band, n_left, n_right;
    logic            off_track;
    logic            n_side_left, n_side_right;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width     <= RST_FRAME_WIDTH;
            r_frame_height    <= RST_FRAME_HEIGHT;
            r_grey_tolerance  <= RST_GREY_TOLERANCE;
            r_off_track_limit <= RST_OFF_TRACK_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FRAME_WIDTH:     r_frame_width     <= i_cfg.data[CFG_W-1:0];
                REG_FRAME_HEIGHT:    r_frame_height    <= i_cfg.data[CFG_W-1:0];
                REG_GREY_TOLERANCE:  r_grey_tolerance  <= i_cfg.data[PIX_W-1:0];
                REG_OFF_TRACK_LIMIT: r_off_track_limit <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify at acceptance: blue must stand apart from both green and red.
    always_comb begin
        diff_bg = (i_pix.blue_value > i_pix.green_value)
                ? {1'b0, i_pix.blue_value} - {1'b0, i_pix.green_value}
                : {1'b0, i_pix.green_value} - {1'b0, i_pix.blue_value};
        diff_br = (i_pix.blue_value > i_pix.red_value)
                ? {1'b0, i_pix.blue_value} - {1'b0, i_pix.red_value}
                : {1'b0, i_pix.red_value} - {1'b0, i_pix.blue_value};
        nongrey = (diff_bg > {1'b0, r_grey_tolerance}) && (diff_br > {1'b0, r_grey_tolerance});
    end

    // Clamp the programmed size into the supported range.
    always_comb begin
        w_ext = CWW'(r_frame_width);
        if (w_ext < CWW'(MIN_WIDTH)) begin
            w_ext = CWW'(MIN_WIDTH);
        end else if (w_ext > CWW'(MAX_WIDTH)) begin
            w_ext = CWW'(MAX_WIDTH);
        end
        w_eff = w_ext[WW-1:0];

        h_ext = CHW'(r_frame_height);
        if (h_ext < CHW'(MIN_HEIGHT)) begin
            h_ext = CHW'(MIN_HEIGHT);
        end else if (h_ext > CHW'(MAX_HEIGHT)) begin
            h_ext = CHW'(MAX_HEIGHT);
        end
        h_eff = h_ext[HW-1:0];
    end

    // Band test: middle half of the columns, split at half width.
    always_comb begin
        col_ext = WW'(r_col);
        col_x4  = {col_ext, 2'b00};
        w_x3    = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
        in_band = (col_ext >= (w_eff >> 2)) && (col_x4 < w_x3);
        on_left = col_ext < (w_eff >> 1);
        hit     = r_s1_nongrey && in_band;

        row_end   = (col_ext + WW'(1)) >= w_eff;
        frame_end = row_end && ((HW'(r_row) + HW'(1)) >= h_eff);

        // Saturating counts including the current pixel.
        n_band  = (hit && r_band != CNT_MAX) ? r_band + CNT_W'(1) : r_band;
        n_left  = (hit && on_left && r_left != CNT_MAX) ? r_left + CNT_W'(1) : r_left;
        n_right = (hit && !on_left && r_right != CNT_MAX) ? r_right + CNT_W'(1) : r_right;

        // Left wins only on a strictly larger count.
        off_track    = n_band > r_off_track_limit;
        n_side_left  = r_side_left;
        n_side_right = r_side_right;
        if (off_track) begin
            n_side_left  = n_left > n_right;
            n_side_right = !(n_left > n_right);
        end
    end

    // Handshake: a stage-1 pixel advances unless it ends a frame while a result still waits.
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_go       = r_s1_valid && (!frame_end || out_free);
    assign in_ready    = !r_s1_valid || s1_go;
    assign i_pix.ready = in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_pix.valid) begin
            r_s1_nongrey <= nongrey;
        end
    end

    // Position, counters and held side flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_band       <= '0;
            r_left       <= '0;
            r_right      <= '0;
            r_side_left  <= 1'b0;
            r_side_right <= 1'b0;
        end else if (s1_go) begin
            if (frame_end) begin
                // Close the frame: clear positions and counters, keep the new side flags.
                r_col        <= '0;
                r_row        <= '0;
                r_band       <= '0;
                r_left       <= '0;
                r_right      <= '0;
                r_side_left  <= n_side_left;
                r_side_right <= n_side_right;
            end else begin
                r_band  <= n_band;
                r_left  <= n_left;
                r_right <= n_right;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Result register: load at frame end, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && frame_end) begin
            r_out_band   <= n_band;
            r_out_left   <= n_left;
            r_out_right  <= n_right;
            r_out_off    <= off_track;
            r_out_lleft  <= n_side_left;
            r_out_lright <= n_side_right;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.nongrey_total = r_out_band;
    assign o_res.left_total    = r_out_left;
    assign o_res.right_total   = r_out_right;
    assign o_res.off_track     = r_out_off;
    assign o_res.leaving_left  = r_out_lleft;
    assign o_res.leaving_right = r_out_lright;

endmodule
